@@ rtl/ille_pkg.sv @@
// shared types and constants of the indexed linked-list engine
// command and status structs between controller and datapath, op codes, field widths
// no dependencies
package ille_pkg;

	// default table geometry
	localparam int PROC_ENTRIES_DEF = 64;
	localparam int LIST_PAIRS_DEF   = 32;
	localparam int KEY_BITS_DEF     = 32;

	// fixed port field widths
	localparam int OP_W    = 3;
	localparam int ITEM_W  = 6;
	localparam int END_W   = 7;
	localparam int SKEY_W  = 32;
	localparam int VALUE_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_NEW    = 3'd0,
		OP_APPEND = 3'd1,
		OP_REMOVE = 3'd2,
		OP_FIRST  = 3'd3,
		OP_LAST   = 3'd4,
		OP_INSERT = 3'd5
	} op_t;

	// table address sources
	typedef enum logic [3:0] {
		ADR_IN_ITEM,
		ADR_IN_END,
		ADR_ITEM,
		ADR_END,
		ADR_A,
		ADR_B,
		ADR_RD_NEXT,
		ADR_RD_PREV,
		ADR_TAKE
	} adr_sel_t;

	// link write data sources
	typedef enum logic [2:0] {
		LNK_ITEM,
		LNK_END,
		LNK_A,
		LNK_B,
		LNK_NULL,
		LNK_RD_NEXT,
		LNK_RD_PREV
	} lnk_sel_t;

	typedef enum logic [1:0] {
		KY_ZERO,
		KY_MAX,
		KY_NEW
	} key_sel_t;

	typedef enum logic [1:0] {
		A_HOLD,
		A_RD_NEXT,
		A_TAKE
	} a_sel_t;

	typedef enum logic {
		B_HOLD,
		B_RD_PREV
	} b_sel_t;

	typedef struct packed {
		logic     load;
		adr_sel_t rsel;
		a_sel_t   a_sel;
		b_sel_t   b_sel;
		logic     nx_we;
		adr_sel_t nx_addr;
		lnk_sel_t nx_data;
		logic     pv_we;
		adr_sel_t pv_addr;
		lnk_sel_t pv_data;
		logic     ky_we;
		adr_sel_t ky_addr;
		key_sel_t ky_data;
		logic     alloc;
		logic     steps_clr;
		logic     steps_inc;
		logic     set_empty;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic take_ok;
		logic walk_more;
	} stat_t;

endpackage

@@ rtl/ille_ram.sv @@
// one table memory: single write port, one registered read port
// reads beyond the table return a fixed out-of-range word
// no dependencies
module ille_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8,
	parameter int AW = 8,
	parameter logic [WIDTH-1:0] OOB_DATA = '0
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	localparam int IW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic             oob_q;

	always_ff @(posedge clk) begin
		if (we && (waddr < AW'(DEPTH))) begin
			mem[waddr[IW-1:0]] <= wdata;
		end
		rdata_q <= mem[raddr[IW-1:0]];
		oob_q   <= (raddr >= AW'(DEPTH));
	end

	assign rdata = oob_q ? OOB_DATA : rdata_q;

endmodule

@@ rtl/ille_dpath.sv @@
// datapath of the indexed linked-list engine: link and key tables, work registers,
// free sentinel pointer, walk counter and result register
// depends on ille_pkg and ille_ram
module ille_dpath #(
	parameter int PROC_ENTRIES = ille_pkg::PROC_ENTRIES_DEF,
	parameter int LIST_PAIRS = ille_pkg::LIST_PAIRS_DEF,
	parameter int KEY_BITS = ille_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ille_pkg::cmd_t                     cmd,
	output ille_pkg::stat_t                    stat,
	input  logic [ille_pkg::OP_W-1:0]          op,
	input  logic [ille_pkg::ITEM_W-1:0]        item,
	input  logic [ille_pkg::END_W-1:0]         list_end,
	input  logic signed [ille_pkg::SKEY_W-1:0] sort_key,
	output logic [ille_pkg::VALUE_W-1:0]       value,
	output logic                               list_empty,
	output logic                               table_full
);

	localparam int TBL = PROC_ENTRIES + 2 * LIST_PAIRS;
	localparam int LW = $clog2(TBL + 1);
	localparam int AW = (LW > ille_pkg::END_W) ? LW : ille_pkg::END_W;
	localparam logic [AW-1:0] NULL_LINK = AW'(TBL);
	localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};

	ille_pkg::op_t         op_q;
	logic [AW-1:0]         item_q;
	logic [AW-1:0]         end_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [AW-1:0]         a_q;
	logic [AW-1:0]         b_q;
	logic [LW-1:0]         fs_q;
	logic [LW-1:0]         steps_q;
	logic                  full_q;
	logic                  empty_q;
	logic [ille_pkg::VALUE_W-1:0] value_q;
	logic                  list_empty_q;
	logic                  table_full_q;

	logic [AW-1:0]       rd_next;
	logic [AW-1:0]       rd_prev;
	logic [KEY_BITS-1:0] rd_key;
	logic [AW-1:0]       take_x;
	logic [KEY_BITS-1:0] key_new;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       nx_waddr;
	logic [AW-1:0]       pv_waddr;
	logic [AW-1:0]       ky_waddr;
	logic [AW-1:0]       nx_wdata;
	logic [AW-1:0]       pv_wdata;
	logic [KEY_BITS-1:0] ky_wdata;
	logic [LW:0]         fs_plus1;
	logic [LW:0]         fs_plus2;

	function automatic logic [AW-1:0] adr_pick(
		input ille_pkg::adr_sel_t sel,
		input logic [AW-1:0] in_item_x,
		input logic [AW-1:0] in_end_x,
		input logic [AW-1:0] itm,
		input logic [AW-1:0] lend,
		input logic [AW-1:0] ra,
		input logic [AW-1:0] rb,
		input logic [AW-1:0] rnx,
		input logic [AW-1:0] rpv,
		input logic [AW-1:0] tk
	);
		logic [AW-1:0] r;
		case (sel)
			ille_pkg::ADR_IN_ITEM: r = in_item_x;
			ille_pkg::ADR_IN_END:  r = in_end_x;
			ille_pkg::ADR_ITEM:    r = itm;
			ille_pkg::ADR_END:     r = lend;
			ille_pkg::ADR_A:       r = ra;
			ille_pkg::ADR_B:       r = rb;
			ille_pkg::ADR_RD_NEXT: r = rnx;
			ille_pkg::ADR_RD_PREV: r = rpv;
			ille_pkg::ADR_TAKE:    r = tk;
			default:               r = in_item_x;
		endcase
		return r;
	endfunction

	function automatic logic [AW-1:0] lnk_pick(
		input ille_pkg::lnk_sel_t sel,
		input logic [AW-1:0] itm,
		input logic [AW-1:0] lend,
		input logic [AW-1:0] ra,
		input logic [AW-1:0] rb,
		input logic [AW-1:0] rnx,
		input logic [AW-1:0] rpv
	);
		logic [AW-1:0] r;
		case (sel)
			ille_pkg::LNK_ITEM:    r = itm;
			ille_pkg::LNK_END:     r = lend;
			ille_pkg::LNK_A:       r = ra;
			ille_pkg::LNK_B:       r = rb;
			ille_pkg::LNK_NULL:    r = NULL_LINK;
			ille_pkg::LNK_RD_NEXT: r = rnx;
			ille_pkg::LNK_RD_PREV: r = rpv;
			default:               r = NULL_LINK;
		endcase
		return r;
	endfunction

	// signed key to ascending unsigned order
	always_comb begin
		key_new = KEY_BITS'(sort_key);
		key_new[KEY_BITS-1] = ~key_new[KEY_BITS-1];
	end

	assign take_x   = (op_q == ille_pkg::OP_FIRST) ? rd_next : rd_prev;
	assign fs_plus1 = {1'b0, fs_q} + (LW+1)'(1);
	assign fs_plus2 = {1'b0, fs_q} + (LW+1)'(2);

	assign raddr = adr_pick(cmd.rsel, AW'(item), AW'(list_end), item_q, end_q,
		a_q, b_q, rd_next, rd_prev, take_x);
	assign nx_waddr = adr_pick(cmd.nx_addr, AW'(item), AW'(list_end), item_q, end_q,
		a_q, b_q, rd_next, rd_prev, take_x);
	assign pv_waddr = adr_pick(cmd.pv_addr, AW'(item), AW'(list_end), item_q, end_q,
		a_q, b_q, rd_next, rd_prev, take_x);
	assign ky_waddr = adr_pick(cmd.ky_addr, AW'(item), AW'(list_end), item_q, end_q,
		a_q, b_q, rd_next, rd_prev, take_x);
	assign nx_wdata = lnk_pick(cmd.nx_data, item_q, end_q, a_q, b_q, rd_next, rd_prev);
	assign pv_wdata = lnk_pick(cmd.pv_data, item_q, end_q, a_q, b_q, rd_next, rd_prev);

	always_comb begin
		case (cmd.ky_data)
			ille_pkg::KY_ZERO: ky_wdata = '0;
			ille_pkg::KY_MAX:  ky_wdata = KEY_MAX;
			ille_pkg::KY_NEW:  ky_wdata = key_q;
			default:           ky_wdata = KEY_MAX;
		endcase
	end

	ille_ram #(
		.DEPTH(TBL), .WIDTH(AW), .AW(AW), .OOB_DATA(NULL_LINK)
	) u_next (
		.clk(clk), .we(cmd.nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(raddr), .rdata(rd_next)
	);

	ille_ram #(
		.DEPTH(TBL), .WIDTH(AW), .AW(AW), .OOB_DATA(NULL_LINK)
	) u_prev (
		.clk(clk), .we(cmd.pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(raddr), .rdata(rd_prev)
	);

	ille_ram #(
		.DEPTH(TBL), .WIDTH(KEY_BITS), .AW(AW), .OOB_DATA(KEY_MAX)
	) u_key (
		.clk(clk), .we(cmd.ky_we), .waddr(ky_waddr), .wdata(ky_wdata),
		.raddr(raddr), .rdata(rd_key)
	);

	// free sentinel pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= LW'(PROC_ENTRIES);
		end else if (cmd.alloc) begin
			fs_q <= fs_q + LW'(2);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= ille_pkg::op_t'(op);
			item_q  <= AW'(item);
			end_q   <= AW'(list_end);
			key_q   <= key_new;
			a_q     <= AW'(fs_q);
			b_q     <= AW'(fs_plus1);
			full_q  <= (ille_pkg::op_t'(op) == ille_pkg::OP_NEW) && (fs_plus2 > (LW+1)'(TBL));
			empty_q <= 1'b0;
		end else begin
			case (cmd.a_sel)
				ille_pkg::A_RD_NEXT: a_q <= rd_next;
				ille_pkg::A_TAKE:    a_q <= take_x;
				default:             ;
			endcase
			if (cmd.b_sel == ille_pkg::B_RD_PREV) begin
				b_q <= rd_prev;
			end
			if (cmd.set_empty) begin
				empty_q <= 1'b1;
			end
		end

		if (cmd.steps_clr) begin
			steps_q <= '0;
		end else if (cmd.steps_inc) begin
			steps_q <= steps_q + LW'(1);
		end

		if (cmd.out_load) begin
			case (op_q)
				ille_pkg::OP_NEW:    value_q <= full_q ? '0 : ille_pkg::VALUE_W'(a_q);
				ille_pkg::OP_APPEND,
				ille_pkg::OP_REMOVE,
				ille_pkg::OP_INSERT: value_q <= ille_pkg::VALUE_W'(item_q);
				ille_pkg::OP_FIRST,
				ille_pkg::OP_LAST:   value_q <= empty_q ? '0 : ille_pkg::VALUE_W'(a_q);
				default:             value_q <= '0;
			endcase
			list_empty_q <= empty_q;
			table_full_q <= full_q;
		end
	end

	assign stat.full      = full_q;
	assign stat.take_ok   = (take_x < AW'(PROC_ENTRIES));
	assign stat.walk_more = (rd_key < key_q) && (steps_q < LW'(TBL));

	assign value      = value_q;
	assign list_empty = list_empty_q;
	assign table_full = table_full_q;

endmodule

@@ rtl/ille_ctrl.sv @@
// sequencer of the indexed linked-list engine: one state per table access step
// drives the datapath command struct and both handshakes
// depends on ille_pkg
module ille_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [ille_pkg::OP_W-1:0] op,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  ille_pkg::stat_t           stat,
	output ille_pkg::cmd_t            cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NEW_HEAD,
		ST_NEW_TAIL,
		ST_APP_LINK,
		ST_APP_FIX,
		ST_UNLINK,
		ST_TAKE,
		ST_INS_START,
		ST_INS_WALK,
		ST_INS_FIX,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	ille_pkg::op_t op_in;

	assign op_in = ille_pkg::op_t'(op);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.rsel = (op_in == ille_pkg::OP_REMOVE) ? ille_pkg::ADR_IN_ITEM
					: ille_pkg::ADR_IN_END;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (op_in)
						ille_pkg::OP_NEW:    state_d = ST_NEW_HEAD;
						ille_pkg::OP_APPEND: state_d = ST_APP_LINK;
						ille_pkg::OP_REMOVE: state_d = ST_UNLINK;
						ille_pkg::OP_FIRST,
						ille_pkg::OP_LAST:   state_d = ST_TAKE;
						ille_pkg::OP_INSERT: state_d = ST_INS_START;
						default:             state_d = ST_FIN;
					endcase
				end
			end
			ST_NEW_HEAD: begin
				if (stat.full) begin
					state_d = ST_FIN;
				end else begin
					cmd.nx_we   = 1'b1;
					cmd.nx_addr = ille_pkg::ADR_A;
					cmd.nx_data = ille_pkg::LNK_B;
					cmd.pv_we   = 1'b1;
					cmd.pv_addr = ille_pkg::ADR_A;
					cmd.pv_data = ille_pkg::LNK_NULL;
					cmd.ky_we   = 1'b1;
					cmd.ky_addr = ille_pkg::ADR_A;
					cmd.ky_data = ille_pkg::KY_ZERO;
					state_d     = ST_NEW_TAIL;
				end
			end
			ST_NEW_TAIL: begin
				cmd.nx_we   = 1'b1;
				cmd.nx_addr = ille_pkg::ADR_B;
				cmd.nx_data = ille_pkg::LNK_NULL;
				cmd.pv_we   = 1'b1;
				cmd.pv_addr = ille_pkg::ADR_B;
				cmd.pv_data = ille_pkg::LNK_A;
				cmd.ky_we   = 1'b1;
				cmd.ky_addr = ille_pkg::ADR_B;
				cmd.ky_data = ille_pkg::KY_MAX;
				cmd.alloc   = 1'b1;
				state_d     = ST_FIN;
			end
			ST_APP_LINK: begin
				// read data holds the tail's previous link
				cmd.nx_we   = 1'b1;
				cmd.nx_addr = ille_pkg::ADR_ITEM;
				cmd.nx_data = ille_pkg::LNK_END;
				cmd.pv_we   = 1'b1;
				cmd.pv_addr = ille_pkg::ADR_ITEM;
				cmd.pv_data = ille_pkg::LNK_RD_PREV;
				cmd.b_sel   = ille_pkg::B_RD_PREV;
				state_d     = ST_APP_FIX;
			end
			ST_APP_FIX: begin
				cmd.nx_we   = 1'b1;
				cmd.nx_addr = ille_pkg::ADR_B;
				cmd.nx_data = ille_pkg::LNK_ITEM;
				cmd.pv_we   = 1'b1;
				cmd.pv_addr = ille_pkg::ADR_END;
				cmd.pv_data = ille_pkg::LNK_ITEM;
				state_d     = ST_FIN;
			end
			ST_UNLINK: begin
				// read data holds both links of the entry being unlinked
				cmd.nx_we   = 1'b1;
				cmd.nx_addr = ille_pkg::ADR_RD_PREV;
				cmd.nx_data = ille_pkg::LNK_RD_NEXT;
				cmd.pv_we   = 1'b1;
				cmd.pv_addr = ille_pkg::ADR_RD_NEXT;
				cmd.pv_data = ille_pkg::LNK_RD_PREV;
				state_d     = ST_FIN;
			end
			ST_TAKE: begin
				if (stat.take_ok) begin
					cmd.a_sel = ille_pkg::A_TAKE;
					cmd.rsel  = ille_pkg::ADR_TAKE;
					state_d   = ST_UNLINK;
				end else begin
					cmd.set_empty = 1'b1;
					state_d       = ST_FIN;
				end
			end
			ST_INS_START: begin
				cmd.a_sel     = ille_pkg::A_RD_NEXT;
				cmd.rsel      = ille_pkg::ADR_RD_NEXT;
				cmd.steps_clr = 1'b1;
				state_d       = ST_INS_WALK;
			end
			ST_INS_WALK: begin
				cmd.rsel = ille_pkg::ADR_RD_NEXT;
				if (stat.walk_more) begin
					cmd.a_sel     = ille_pkg::A_RD_NEXT;
					cmd.steps_inc = 1'b1;
				end else begin
					cmd.b_sel   = ille_pkg::B_RD_PREV;
					cmd.nx_we   = 1'b1;
					cmd.nx_addr = ille_pkg::ADR_ITEM;
					cmd.nx_data = ille_pkg::LNK_A;
					cmd.pv_we   = 1'b1;
					cmd.pv_addr = ille_pkg::ADR_ITEM;
					cmd.pv_data = ille_pkg::LNK_RD_PREV;
					cmd.ky_we   = 1'b1;
					cmd.ky_addr = ille_pkg::ADR_ITEM;
					cmd.ky_data = ille_pkg::KY_NEW;
					state_d     = ST_INS_FIX;
				end
			end
			ST_INS_FIX: begin
				cmd.nx_we   = 1'b1;
				cmd.nx_addr = ille_pkg::ADR_B;
				cmd.nx_data = ille_pkg::LNK_ITEM;
				cmd.pv_we   = 1'b1;
				cmd.pv_addr = ille_pkg::ADR_A;
				cmd.pv_data = ille_pkg::LNK_ITEM;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/indexed_linked_list_engine_core.sv @@
// top level of the indexed linked-list engine
// joins the sequencer and the datapath; depends on ille_pkg, ille_ctrl, ille_dpath
//
// A table of PROC_ENTRIES process entries followed by LIST_PAIRS head/tail sentinel
// pairs holds doubly linked lists. Each input word carries one operation and yields
// exactly one output word: new list (value = head index, table_full when no pair is
// left), append before a tail, remove an item, take first or take last (list_empty
// when the list holds no process), and ordered insert by ascending signed key.
// The block works on one word at a time; in_stall is high from acceptance until the
// result has been loaded into the output register, and the output register lets the
// next word in while a result still waits. The time each word takes is set by the
// single write port of each of the next-link, previous-link and key memories (one
// write per memory per cycle) and by the insert walk, which follows one link per
// cycle through their shared registered read port. The tables are not cleared after
// reset; an entry reads as garbage until written, and a fresh list is fully
// initialized by new list.
module indexed_linked_list_engine_core #(
	parameter int PROC_ENTRIES = ille_pkg::PROC_ENTRIES_DEF,
	parameter int LIST_PAIRS = ille_pkg::LIST_PAIRS_DEF,
	parameter int KEY_BITS = ille_pkg::KEY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input word
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ille_pkg::OP_W-1:0]          op,
	input  logic [ille_pkg::ITEM_W-1:0]        item,
	input  logic [ille_pkg::END_W-1:0]         list_end,
	input  logic signed [ille_pkg::SKEY_W-1:0] sort_key,
	// result word
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ille_pkg::VALUE_W-1:0]       value,
	output logic                               list_empty,
	output logic                               table_full
);

	// per-cycle step commands and datapath flags
	ille_pkg::cmd_t  cmd;
	ille_pkg::stat_t stat;

	// sequencer: one state per table access step, owns both handshakes
	ille_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// tables, work registers, free pair pointer and result register
	ille_dpath #(
		.PROC_ENTRIES (PROC_ENTRIES),
		.LIST_PAIRS   (LIST_PAIRS),
		.KEY_BITS     (KEY_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (op),
		.item       (item),
		.list_end   (list_end),
		.sort_key   (sort_key),
		.value      (value),
		.list_empty (list_empty),
		.table_full (table_full)
	);

endmodule

@@ bench/indexed_linked_list_engine_core_tb.sv @@
// bench for the indexed linked-list engine: directed and random list operations
// checked word by word against a list table predictor kept in a scoreboard class
// depends on ille_pkg and indexed_linked_list_engine_core

typedef struct packed {
	logic [ille_pkg::VALUE_W-1:0] value;
	logic                         list_empty;
	logic                         table_full;
} list_result_t;

class list_engine_scoreboard;
	localparam int PROC = ille_pkg::PROC_ENTRIES_DEF;
	localparam int TBL_SIZE = PROC + 2 * ille_pkg::LIST_PAIRS_DEF;
	localparam int NULL_LINK = TBL_SIZE;
	localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

	// keys held with the sign bit flipped so unsigned order is signed order
	int unsigned  next_of[TBL_SIZE];
	int unsigned  prev_of[TBL_SIZE];
	bit [31:0]    key_of[TBL_SIZE];
	bit           next_set[TBL_SIZE];
	bit           prev_set[TBL_SIZE];
	bit           key_set[TBL_SIZE];
	bit           linked[PROC];
	int unsigned  free_slot;
	list_result_t expected_words[$];
	int           errors;

	function new();
		free_slot = PROC;
		errors = 0;
	endfunction

	function int unsigned rd_next(int unsigned i);
		return (i < TBL_SIZE) ? next_of[i] : NULL_LINK;
	endfunction

	function int unsigned rd_prev(int unsigned i);
		return (i < TBL_SIZE) ? prev_of[i] : NULL_LINK;
	endfunction

	function bit [31:0] rd_key(int unsigned i);
		return (i < TBL_SIZE) ? key_of[i] : '1;
	endfunction

	function void wr_next(int unsigned i, int unsigned v);
		if (i < TBL_SIZE) begin
			next_of[i] = v;
			next_set[i] = 1'b1;
		end
	endfunction

	function void wr_prev(int unsigned i, int unsigned v);
		if (i < TBL_SIZE) begin
			prev_of[i] = v;
			prev_set[i] = 1'b1;
		end
	endfunction

	function void wr_key(int unsigned i, bit [31:0] v);
		if (i < TBL_SIZE) begin
			key_of[i] = v;
			key_set[i] = 1'b1;
		end
	endfunction

	function bit has_next(int unsigned i);
		return i >= TBL_SIZE || next_set[i];
	endfunction

	function bit has_prev(int unsigned i);
		return i >= TBL_SIZE || prev_set[i];
	endfunction

	function bit has_key(int unsigned i);
		return i >= TBL_SIZE || key_set[i];
	endfunction

	function void unlink(int unsigned i);
		wr_next(rd_prev(i), rd_next(i));
		wr_prev(rd_next(i), rd_prev(i));
	endfunction

	function int pending();
		return expected_words.size();
	endfunction

	// 1 when the word only reads entries that have been written
	function bit reads_written_only(logic [2:0] cmd, int unsigned it, int unsigned end_idx,
			logic [31:0] skey);
		int unsigned p;
		int unsigned nx;
		int unsigned steps;
		bit [31:0] k;
		case (cmd)
			ille_pkg::OP_APPEND: return has_prev(end_idx);
			ille_pkg::OP_REMOVE: return has_prev(it) && has_next(it);
			ille_pkg::OP_FIRST, ille_pkg::OP_LAST: begin
				if (cmd == ille_pkg::OP_FIRST) begin
					if (!has_next(end_idx))
						return 1'b0;
					p = rd_next(end_idx);
				end else begin
					if (!has_prev(end_idx))
						return 1'b0;
					p = rd_prev(end_idx);
				end
				return p >= PROC || (has_prev(p) && has_next(p));
			end
			ille_pkg::OP_INSERT: begin
				if (!has_next(end_idx))
					return 1'b0;
				k = skey ^ SIGN_FLIP;
				nx = rd_next(end_idx);
				steps = 0;
				while (1) begin
					if (!has_key(nx))
						return 1'b0;
					if (!(rd_key(nx) < k && steps < TBL_SIZE))
						break;
					if (!has_next(nx))
						return 1'b0;
					nx = rd_next(nx);
					steps++;
				end
				return has_prev(nx);
			end
			default: return 1'b1;
		endcase
	endfunction

	// apply one accepted word to the table and queue the word it must answer
	function void note_word(logic [2:0] cmd, int unsigned it, int unsigned end_idx,
			logic [31:0] skey);
		list_result_t r;
		int unsigned p;
		int unsigned nx;
		int unsigned prv;
		int unsigned steps;
		bit [31:0] k;
		r = '0;
		case (cmd)
			ille_pkg::OP_NEW: begin
				if (free_slot + 2 > TBL_SIZE) begin
					r.table_full = 1'b1;
				end else begin
					p = free_slot;
					free_slot += 2;
					wr_next(p, p + 1);
					wr_prev(p, NULL_LINK);
					wr_key(p, '0);
					wr_next(p + 1, NULL_LINK);
					wr_prev(p + 1, p);
					wr_key(p + 1, '1);
					r.value = p[ille_pkg::VALUE_W-1:0];
				end
			end
			ille_pkg::OP_APPEND: begin
				wr_next(it, end_idx);
				wr_prev(it, rd_prev(end_idx));
				wr_next(rd_prev(end_idx), it);
				wr_prev(end_idx, it);
				linked[it] = 1'b1;
				r.value = it[ille_pkg::VALUE_W-1:0];
			end
			ille_pkg::OP_REMOVE: begin
				unlink(it);
				linked[it] = 1'b0;
				r.value = it[ille_pkg::VALUE_W-1:0];
			end
			ille_pkg::OP_FIRST, ille_pkg::OP_LAST: begin
				p = (cmd == ille_pkg::OP_FIRST) ? rd_next(end_idx) : rd_prev(end_idx);
				if (p < PROC) begin
					unlink(p);
					linked[p] = 1'b0;
					r.value = p[ille_pkg::VALUE_W-1:0];
				end else begin
					r.list_empty = 1'b1;
				end
			end
			ille_pkg::OP_INSERT: begin
				k = skey ^ SIGN_FLIP;
				nx = rd_next(end_idx);
				steps = 0;
				while (rd_key(nx) < k && steps < TBL_SIZE) begin
					nx = rd_next(nx);
					steps++;
				end
				wr_next(it, nx);
				prv = rd_prev(nx);
				wr_prev(it, prv);
				wr_key(it, k);
				wr_next(prv, it);
				wr_prev(nx, it);
				linked[it] = 1'b1;
				r.value = it[ille_pkg::VALUE_W-1:0];
			end
			default: ;
		endcase
		expected_words.push_back(r);
	endfunction

	function void check_word(list_result_t got);
		list_result_t want;
		if (expected_words.size() == 0) begin
			errors++;
			$display("%0t: result word with none expected: value %0d empty %0b full %0b",
				$time, got.value, got.list_empty, got.table_full);
			return;
		end
		want = expected_words.pop_front();
		if (got !== want) begin
			errors++;
			$display("%0t: result mismatch: expected value %0d empty %0b full %0b, %s %0d %0b %0b",
				$time, want.value, want.list_empty, want.table_full,
				"actual value/empty/full", got.value, got.list_empty, got.table_full);
		end
	endfunction
endclass

module indexed_linked_list_engine_core_tb;

	localparam int PROC = ille_pkg::PROC_ENTRIES_DEF;
	localparam int TBL_SIZE = PROC + 2 * ille_pkg::LIST_PAIRS_DEF;
	// the two op codes the engine does not know
	localparam logic [ille_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [ille_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

	// run shape, counted in words sent
	localparam int WORD_TARGET = 1450;
	localparam int HOLD_AT = 400;
	localparam int HOLD_LEN = 300;
	localparam int CALM_LO = 700;
	localparam int CALM_HI = 900;
	localparam int PAUSE_AT = 1000;
	// cycles
	localparam int SETTLE = 20;
	localparam int LIMIT = 1_000_000;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic [ille_pkg::OP_W-1:0]           op = '0;
	logic [ille_pkg::ITEM_W-1:0]         item = '0;
	logic [ille_pkg::END_W-1:0]          list_end = '0;
	logic signed [ille_pkg::SKEY_W-1:0]  sort_key = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [ille_pkg::VALUE_W-1:0]        value;
	logic                                list_empty;
	logic                                table_full;

	list_engine_scoreboard table_sb = new();
	int unsigned words_sent = 0;

	indexed_linked_list_engine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.item      (item),
		.list_end  (list_end),
		.sort_key  (sort_key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.list_empty(list_empty),
		.table_full(table_full)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// offer one word and hold it until the engine takes it; an idle gap, or the
	// full drain pause, comes first with valid low
	task automatic send_word(logic [ille_pkg::OP_W-1:0] c, logic [ille_pkg::ITEM_W-1:0] it,
			logic [ille_pkg::END_W-1:0] e, logic [ille_pkg::SKEY_W-1:0] k);
		bit calm;
		calm = words_sent >= CALM_LO && words_sent < CALM_HI;
		if (words_sent == PAUSE_AT) begin
			// sender waits until every expected word is back
			in_valid <= 1'b0;
			@(posedge clk);
			while (table_sb.pending() != 0) @(posedge clk);
		end else if (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		op <= c;
		item <= it;
		list_end <= e;
		sort_key <= k;
		in_valid <= 1'b1;
		// accepted at the first edge that sees stall low
		do @(posedge clk); while (in_stall !== 1'b0);
		table_sb.note_word(c, 32'(it), 32'(e), k);
		words_sent++;
	endtask

	// pick a random word that never reads a table entry before it is written;
	// even pairs hold appended lists without keys, odd pairs hold ordered lists
	task automatic choose_word(output logic [ille_pkg::OP_W-1:0] c,
			output logic [ille_pkg::ITEM_W-1:0] it,
			output logic [ille_pkg::END_W-1:0] e, output logic [ille_pkg::SKEY_W-1:0] k);
		int unsigned lists;
		int unsigned roll;
		int unsigned pair;
		int free_items[$];
		int busy_items[$];
		for (int i = 0; i < PROC; i++) begin
			if (table_sb.linked[i])
				busy_items.push_back(i);
			else
				free_items.push_back(i);
		end
		lists = (table_sb.free_slot - PROC) / 2;
		for (int tries = 0; tries < 24; tries++) begin
			roll = $urandom_range(99);
			// many items in lists: lean toward taking them out
			if (busy_items.size() > 40 && roll >= 14 && roll < 60)
				roll += 40;
			pair = (lists != 0) ? $urandom_range(lists - 1) : 0;
			it = ille_pkg::ITEM_W'($urandom_range(PROC - 1));
			e = ille_pkg::END_W'($urandom_range(TBL_SIZE - 1));
			// extremes, near-zero ties, or anything
			case ($urandom_range(3))
				0: begin
					case ($urandom_range(3))
						0: k = 32'h8000_0000;
						1: k = 32'h7fff_ffff;
						2: k = '0;
						default: k = '1;
					endcase
				end
				1: k = $urandom_range(8) - 4;
				default: k = $urandom;
			endcase
			if (lists == 0 || roll < 4) begin
				c = ille_pkg::OP_NEW;
			end else if (roll < 14) begin
				// noise: any op, any indexes
				c = ille_pkg::OP_W'($urandom_range(7));
			end else if (roll < 37) begin
				c = ille_pkg::OP_APPEND;
				e = ille_pkg::END_W'(PROC + 2 * (pair & ~1) + 1);
				if (free_items.size() != 0)
					it = ille_pkg::ITEM_W'(free_items[$urandom_range(free_items.size() - 1)]);
			end else if (roll < 60) begin
				c = ille_pkg::OP_INSERT;
				if ((pair | 1) < lists)
					pair = pair | 1;
				e = ille_pkg::END_W'(PROC + 2 * pair);
				if (free_items.size() != 0)
					it = ille_pkg::ITEM_W'(free_items[$urandom_range(free_items.size() - 1)]);
			end else if (roll < 78) begin
				c = ille_pkg::OP_REMOVE;
				if (busy_items.size() != 0)
					it = ille_pkg::ITEM_W'(busy_items[$urandom_range(busy_items.size() - 1)]);
			end else begin
				c = ($urandom_range(1) != 0) ? ille_pkg::OP_FIRST : ille_pkg::OP_LAST;
				e = ille_pkg::END_W'(PROC + 2 * pair + ((c == ille_pkg::OP_LAST) ? 1 : 0));
			end
			if (table_sb.reads_written_only(c, 32'(it), 32'(e), k))
				return;
		end
		c = OP_SPARE_A;
	endtask

	// result side: random stall, one long hold-off that backs the engine up,
	// and a calm stretch with no stall at all
	initial begin : result_sink
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && words_sent >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (words_sent >= CALM_LO && words_sent < CALM_HI) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 34);
			end
		end
	end

	// every word taken from the output goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			table_sb.check_word({value, list_empty, table_full});
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("indexed_linked_list_engine_core verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [ille_pkg::OP_W-1:0] c;
		logic [ille_pkg::ITEM_W-1:0] it;
		logic [ille_pkg::END_W-1:0] e;
		logic [ille_pkg::SKEY_W-1:0] k;
		int unsigned useful;
		useful = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two lists: 64/65 takes appends, 66/67 takes ordered inserts
		send_word(ille_pkg::OP_NEW, 0, 0, 0);
		send_word(ille_pkg::OP_NEW, 0, 0, 0);
		// take from a list with no process
		send_word(ille_pkg::OP_FIRST, 0, 64, 0);
		send_word(ille_pkg::OP_LAST, 0, 65, 0);
		// lowest and highest item
		send_word(ille_pkg::OP_APPEND, 0, 65, 0);
		send_word(ille_pkg::OP_APPEND, 63, 65, 0);
		// key extremes, zero and minus one
		send_word(ille_pkg::OP_INSERT, 1, 66, 32'h8000_0000);
		send_word(ille_pkg::OP_INSERT, 2, 66, 32'h7fff_ffff);
		send_word(ille_pkg::OP_INSERT, 3, 66, 32'h0000_0000);
		send_word(ille_pkg::OP_INSERT, 4, 66, 32'hffff_ffff);
		// insert starting from a tail: walk hits the null link, writes past the table
		send_word(ille_pkg::OP_INSERT, 5, 67, 32'h0000_0005);
		send_word(ille_pkg::OP_FIRST, 0, 64, 0);
		send_word(ille_pkg::OP_LAST, 0, 65, 0);
		send_word(ille_pkg::OP_REMOVE, 3, 0, 0);
		// take first on a tail, take last on a head
		send_word(ille_pkg::OP_FIRST, 0, 67, 0);
		send_word(ille_pkg::OP_LAST, 0, 66, 0);
		// unknown ops
		send_word(OP_SPARE_A, 42, 99, 32'h5a5a_a5a5);
		send_word(OP_SPARE_B, 63, 127, 32'hffff_ffff);
		// self-looped item makes the next ordered insert run away
		send_word(ille_pkg::OP_NEW, 0, 0, 0);
		send_word(ille_pkg::OP_INSERT, 10, 68, 32'h0000_0000);
		send_word(ille_pkg::OP_APPEND, 10, 10, 0);
		send_word(ille_pkg::OP_INSERT, 11, 68, 32'h7fff_ffff);
		// remove an item whose both links are null
		send_word(ille_pkg::OP_REMOVE, 5, 0, 0);

		while (useful < WORD_TARGET) begin
			choose_word(c, it, e, k);
			send_word(c, it, e, k);
			if (c != OP_SPARE_A && c != OP_SPARE_B)
				useful++;
		end
		in_valid <= 1'b0;

		while (table_sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (table_sb.errors == 0)
			$display("indexed_linked_list_engine_core verification clean");
		else
			$display("indexed_linked_list_engine_core verification failed");
		$finish;
	end

endmodule
